/* src/tsp_pkg.sv */
`default_nettype none

package tsp_pkg;

  localparam int ID_MAX_LEN_DEF  = 8;
  localparam int FRAC_DIGITS_DEF = 6;
  localparam int N_DEC           = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_POINT  = 8'h2e;

  localparam logic [47:0] SAT_MAG = 48'h8000_0000_0000;

  typedef enum logic [3:0] {
    PH_D1, PH_D2, PH_ID, PH_SEQ0, PH_SEQ, PH_DSTART, PH_DSIGN, PH_DINT,
    PH_DFRAC, PH_BAT0, PH_BAT, PH_SKIP, PH_HEX, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK, ST_BAD_START, ST_NO_STAR, ST_BAD_HEX, ST_CSUM, ST_SYNTAX
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } beat_t;

  typedef struct packed {
    status_t                status;
    logic [63:0]            id_bytes;
    logic [3:0]             id_length;
    logic [31:0]            sequence_res;
    logic [N_DEC-1:0][47:0] decimals;
    logic [15:0]            battery;
  } result_t;

  function automatic logic [29:0] pow10(input logic [3:0] k);
    logic [29:0] v;
    case (k)
      4'd0:    v = 30'd1;
      4'd1:    v = 30'd10;
      4'd2:    v = 30'd100;
      4'd3:    v = 30'd1000;
      4'd4:    v = 30'd10000;
      4'd5:    v = 30'd100000;
      4'd6:    v = 30'd1000000;
      4'd7:    v = 30'd10000000;
      4'd8:    v = 30'd100000000;
      4'd9:    v = 30'd1000000000;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/tsp_in_if.sv */
`default_nettype none

interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink (input valid, input ch, input end_of_line, output ready);
endinterface

`default_nettype wire

/* src/tsp_out_if.sv */
`default_nettype none

interface tsp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [63:0]        id_bytes;
  logic [3:0]         id_length;
  logic [31:0]        sequence_res;
  logic signed [47:0] latitude;
  logic signed [47:0] longitude;
  logic signed [47:0] altitude;
  logic signed [47:0] temperature;
  logic signed [47:0] humidity;
  logic signed [47:0] pressure;
  logic [15:0]        battery;

  modport source (
    output valid, output status, output id_bytes, output id_length,
    output sequence_res, output latitude, output longitude, output altitude,
    output temperature, output humidity, output pressure, output battery,
    input ready
  );
  modport sink (
    input valid, input status, input id_bytes, input id_length,
    input sequence_res, input latitude, input longitude, input altitude,
    input temperature, input humidity, input pressure, input battery,
    output ready
  );
endinterface

`default_nettype wire

/* src/tsp_in_stage.sv */
`default_nettype none

module tsp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tsp_in_if.sink             in_chan,
  input  wire logic          take,
  output logic               beat_valid,
  output tsp_pkg::beat_t     beat
);
  import tsp_pkg::*;

  logic  valid_r, valid_nxt;
  beat_t beat_r;
  logic  load;

  assign in_chan.ready = !valid_r || take;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r.ch  <= in_chan.ch;
      beat_r.eol <= in_chan.end_of_line;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

`default_nettype wire

/* src/tsp_parse_core.sv */
`default_nettype none

module tsp_parse_core #(
  parameter int ID_MAX_LEN  = tsp_pkg::ID_MAX_LEN_DEF,
  parameter int FRAC_DIGITS = tsp_pkg::FRAC_DIGITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            beat_valid,
  input  wire tsp_pkg::beat_t  beat,
  input  wire logic            res_ready,
  output logic                 take,
  output logic                 res_valid,
  output tsp_pkg::result_t     res
);
  import tsp_pkg::*;

  localparam int          FD_W = $clog2(FRAC_DIGITS + 1);
  localparam logic [29:0] UNIT = pow10(4'(FRAC_DIGITS));

  phase_t                 ph_r, ph_nxt;
  logic [2:0]             fi_r, fi_nxt;
  logic [7:0]             xor_r, xor_nxt;
  logic [47:0]            acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic [FD_W-1:0]        fs_r, fs_nxt;
  logic [63:0]            id_r, id_nxt;
  logic [3:0]             idc_r, idc_nxt;
  logic [31:0]            seq_r, seq_nxt;
  logic [N_DEC-1:0][47:0] dec_r, dec_nxt;
  logic [15:0]            bat_r, bat_nxt;
  logic [7:0]             hv_r, hv_nxt;
  logic [1:0]             hc_r, hc_nxt;
  status_t                err_r, err_nxt;

  logic [7:0]      c;
  logic [3:0]      d;
  logic            is_dig;
  logic [4:0]      hex_d;
  logic            syn_err;
  logic            store;
  logic [51:0]     int_sum;
  logic [51:0]     frac_sum;
  logic [33:0]     int_add;
  logic [33:0]     frac_add;
  logic [FD_W-1:0] fs_inc;
  logic [47:0]     dec_val;
  status_t         status_c;

  function automatic logic [4:0] hex_of(input logic [7:0] x);
    logic [4:0] r;
    r = 5'd0;
    if (x >= 8'h30 && x <= 8'h39) begin
      r = {1'b1, x[3:0]};
    end else if ((x >= 8'h61 && x <= 8'h66) || (x >= 8'h41 && x <= 8'h46)) begin
      r = {1'b1, x[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign c      = beat.ch;
  assign d      = c[3:0];
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign hex_d  = hex_of(c);

  assign int_add  = 34'(d) * 34'(UNIT);
  assign int_sum  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 52'(int_add);
  assign fs_inc   = fs_r + 1'b1;
  assign frac_add = 34'(d) * 34'(pow10(4'(FRAC_DIGITS) - 4'(fs_inc)));
  assign frac_sum = {4'b0, acc_r} + 52'(frac_add);

  always_comb begin
    if (neg_r) begin
      dec_val = 48'd0 - acc_r;
    end else if (acc_r > SAT_MAG - 48'd1) begin
      dec_val = SAT_MAG - 48'd1;
    end else begin
      dec_val = acc_r;
    end
  end

  always_comb begin
    ph_nxt  = ph_r;
    fi_nxt  = fi_r;
    xor_nxt = xor_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    fs_nxt  = fs_r;
    id_nxt  = id_r;
    idc_nxt = idc_r;
    seq_nxt = seq_r;
    dec_nxt = dec_r;
    bat_nxt = bat_r;
    hv_nxt  = hv_r;
    hc_nxt  = hc_r;
    err_nxt = err_r;
    syn_err = 1'b0;
    store   = 1'b0;
    if (ph_r >= PH_ID && ph_r <= PH_SKIP && c == CH_STAR) begin
      if (ph_r != PH_BAT && err_r == ST_OK) begin
        err_nxt = ST_SYNTAX;
      end
      ph_nxt = PH_HEX;
      hc_nxt = 2'd0;
      hv_nxt = 8'd0;
    end else begin
      if (ph_r < PH_HEX) begin
        xor_nxt = xor_r ^ c;
      end
      case (ph_r)
        PH_D1, PH_D2: begin
          if (c == CH_DOLLAR) begin
            ph_nxt = (ph_r == PH_D1) ? PH_D2 : PH_ID;
          end else begin
            err_nxt = ST_BAD_START;
            ph_nxt  = PH_DONE;
          end
        end
        PH_ID: begin
          if (c == CH_COMMA) begin
            ph_nxt = PH_SEQ0;
          end else if (idc_r < 4'(ID_MAX_LEN)) begin
            id_nxt  = id_r | ({56'd0, c} << {idc_r[2:0], 3'b000});
            idc_nxt = idc_r + 4'd1;
          end else begin
            syn_err = 1'b1;
          end
        end
        PH_SEQ0, PH_SEQ: begin
          if (is_dig) begin
            seq_nxt = {seq_r[28:0], 3'b000} + {seq_r[30:0], 1'b0} + 32'(d);
            ph_nxt  = PH_SEQ;
          end else if (c == CH_COMMA && ph_r == PH_SEQ) begin
            fi_nxt  = 3'd0;
            acc_nxt = 48'd0;
            neg_nxt = 1'b0;
            fs_nxt  = '0;
            ph_nxt  = PH_DSTART;
          end else begin
            syn_err = 1'b1;
          end
        end
        PH_DSTART, PH_DSIGN: begin
          if (c == CH_MINUS && ph_r == PH_DSTART) begin
            neg_nxt = 1'b1;
            ph_nxt  = PH_DSIGN;
          end else if (is_dig) begin
            acc_nxt = (int_sum > {4'b0, SAT_MAG}) ? SAT_MAG : int_sum[47:0];
            ph_nxt  = PH_DINT;
          end else if (c == CH_POINT) begin
            ph_nxt = PH_DFRAC;
          end else begin
            syn_err = 1'b1;
          end
        end
        PH_DINT: begin
          if (is_dig) begin
            acc_nxt = (int_sum > {4'b0, SAT_MAG}) ? SAT_MAG : int_sum[47:0];
          end else if (c == CH_POINT) begin
            ph_nxt = PH_DFRAC;
          end else if (c == CH_COMMA) begin
            store = 1'b1;
          end else begin
            syn_err = 1'b1;
          end
        end
        PH_DFRAC: begin
          if (is_dig) begin
            if (fs_r < FD_W'(FRAC_DIGITS)) begin
              fs_nxt  = fs_inc;
              acc_nxt = (frac_sum > {4'b0, SAT_MAG}) ? SAT_MAG : frac_sum[47:0];
            end
          end else if (c == CH_COMMA) begin
            store = 1'b1;
          end else begin
            syn_err = 1'b1;
          end
        end
        PH_BAT0, PH_BAT: begin
          if (is_dig) begin
            bat_nxt = {bat_r[12:0], 3'b000} + {bat_r[14:0], 1'b0} + 16'(d);
            ph_nxt  = PH_BAT;
          end else begin
            syn_err = 1'b1;
          end
        end
        PH_HEX: begin
          if (hex_d[4] && hc_r < 2'd2) begin
            hv_nxt = {hv_r[3:0], hex_d[3:0]};
            hc_nxt = hc_r + 2'd1;
            if (hc_r == 2'd1) begin
              ph_nxt = PH_DONE;
            end
          end else begin
            ph_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      if (store) begin
        dec_nxt[fi_r] = dec_val;
        fi_nxt        = fi_r + 3'd1;
        acc_nxt       = 48'd0;
        neg_nxt       = 1'b0;
        fs_nxt        = '0;
        ph_nxt        = (fi_r + 3'd1 >= 3'(N_DEC)) ? PH_BAT0 : PH_DSTART;
      end
      if (syn_err) begin
        if (err_r == ST_OK) begin
          err_nxt = ST_SYNTAX;
        end
        ph_nxt = PH_SKIP;
      end
    end
  end

  always_comb begin
    if (err_nxt == ST_BAD_START || ph_nxt <= PH_D2) begin
      status_c = ST_BAD_START;
    end else if (ph_nxt < PH_HEX) begin
      status_c = ST_NO_STAR;
    end else if (hc_nxt == 2'd0) begin
      status_c = ST_BAD_HEX;
    end else if (xor_nxt != hv_nxt) begin
      status_c = ST_CSUM;
    end else if (err_nxt == ST_SYNTAX) begin
      status_c = ST_SYNTAX;
    end else begin
      status_c = ST_OK;
    end
  end

  always_comb begin
    res        = '0;
    res.status = status_c;
    if (status_c == ST_OK) begin
      res.id_bytes     = id_nxt;
      res.id_length    = idc_nxt;
      res.sequence_res = seq_nxt;
      res.decimals     = dec_nxt;
      res.battery      = bat_nxt;
    end
  end

  assign take      = beat_valid && (!beat.eol || res_ready);
  assign res_valid = beat_valid && beat.eol;

  always_ff @(posedge clk) begin
    if (!rst_n || (take && beat.eol)) begin
      ph_r  <= PH_D1;
      fi_r  <= 3'd0;
      xor_r <= 8'd0;
      acc_r <= 48'd0;
      neg_r <= 1'b0;
      fs_r  <= '0;
      id_r  <= 64'd0;
      idc_r <= 4'd0;
      seq_r <= 32'd0;
      dec_r <= '0;
      bat_r <= 16'd0;
      hv_r  <= 8'd0;
      hc_r  <= 2'd0;
      err_r <= ST_OK;
    end else if (take) begin
      ph_r  <= ph_nxt;
      fi_r  <= fi_nxt;
      xor_r <= xor_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      fs_r  <= fs_nxt;
      id_r  <= id_nxt;
      idc_r <= idc_nxt;
      seq_r <= seq_nxt;
      dec_r <= dec_nxt;
      bat_r <= bat_nxt;
      hv_r  <= hv_nxt;
      hc_r  <= hc_nxt;
      err_r <= err_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_id_len: assert property (@(posedge clk) disable iff (!rst_n)
    idc_r <= 4'(ID_MAX_LEN))
    else $error("id count past limit");
  a_frac_len: assert property (@(posedge clk) disable iff (!rst_n)
    fs_r <= FD_W'(FRAC_DIGITS))
    else $error("fraction digit count past limit");
  a_acc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= SAT_MAG)
    else $error("accumulator past saturation");
  a_hex_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r == 2'd2) |-> (ph_r == PH_DONE))
    else $error("two hex digits without done phase");
  a_line_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (take && beat.eol) |=> (ph_r == PH_D1 && xor_r == 8'd0 && err_r == ST_OK))
    else $error("state not cleared after line");
`endif

endmodule

`default_nettype wire

/* src/tsp_out_stage.sv */
`default_nettype none

module tsp_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             res_valid,
  input  wire tsp_pkg::result_t res,
  output logic                  res_ready,
  tsp_out_if.source             out_chan
);
  import tsp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;
  logic    load;

  assign res_ready = !valid_r || out_chan.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.status       = res_r.status;
  assign out_chan.id_bytes     = res_r.id_bytes;
  assign out_chan.id_length    = res_r.id_length;
  assign out_chan.sequence_res = res_r.sequence_res;
  assign out_chan.latitude     = res_r.decimals[0];
  assign out_chan.longitude    = res_r.decimals[1];
  assign out_chan.altitude     = res_r.decimals[2];
  assign out_chan.temperature  = res_r.decimals[3];
  assign out_chan.humidity     = res_r.decimals[4];
  assign out_chan.pressure     = res_r.decimals[5];
  assign out_chan.battery      = res_r.battery;

endmodule

`default_nettype wire

/* src/telemetry_sentence_parser_unit.sv */
// Telemetry sentence parser.
// in_chan carries one raw byte of a "$$id,seq,lat,lon,alt,temp,hum,press,batt*HH"
// line per beat, with end_of_line high on the last byte of the line.
// out_chan carries one result beat per line: a status code and, when the
// status is ok, the id, sequence, six decimals in signed 10^-FRAC_DIGITS units
// and the battery value; on any other status those fields are zero.
// Throughput: one byte per cycle unless a last byte waits on a full result slot,
// set by the single parse step between the byte register and the result register.
// Path: the last byte of a line is held in the byte register, then its result
// beat in the result register, which drives out_chan.
// Reset: all parser state clears and both registers empty; the first byte
// after reset starts a new line. State also clears after every line.
// Stall: while a result waits on out_chan, bytes that do not end a line keep
// flowing; a last byte holds in the byte register until the result slot is
// free, and in_chan.ready drops until then.
`default_nettype none

module telemetry_sentence_parser_unit #(
  parameter int ID_MAX_LEN  = tsp_pkg::ID_MAX_LEN_DEF,
  parameter int FRAC_DIGITS = tsp_pkg::FRAC_DIGITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tsp_in_if.sink    in_chan,
  tsp_out_if.source out_chan
);
  import tsp_pkg::*;

  logic    beat_valid;
  beat_t   beat;
  logic    take;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  tsp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  tsp_parse_core #(
    .ID_MAX_LEN  (ID_MAX_LEN),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .res_ready  (res_ready),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  tsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire
